// ===== hw/rtl/cct_pkg.sv =====
// shared types, constants and codes for the causal context tracker
`default_nettype none
package cct_pkg;

   localparam int REPLICAS    = 16;
   localparam int CLOUD_SLOTS = 16;
   localparam int REP_W       = (REPLICAS > 1) ? $clog2(REPLICAS) : 1;
   localparam int SLOT_W      = (CLOUD_SLOTS > 1) ? $clog2(CLOUD_SLOTS) : 1;
   localparam int CTR_W       = 31;

   typedef logic [REP_W-1:0]  rep_idx_type;
   typedef logic [SLOT_W-1:0] slot_idx_type;
   typedef logic [CTR_W-1:0]  ctr_type;

   localparam logic [2:0] REQ_MAKE    = 3'd0;
   localparam logic [2:0] REQ_INSERT  = 3'd1;
   localparam logic [2:0] REQ_QUERY   = 3'd2;
   localparam logic [2:0] REQ_MERGE   = 3'd3;
   localparam logic [2:0] REQ_COMPACT = 3'd4;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_SAT  = 2'd2;

   typedef struct packed {
      logic [2:0] req_type;
      logic [3:0] replica;
      ctr_type    dot_counter;
      logic       compact_now;
   } cct_req_type;

   typedef struct packed {
      ctr_type    new_counter;
      logic       known;
      logic [1:0] status;
   } cct_rsp_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] replica;
      ctr_type    ctr;
   } cct_slot_type;

   typedef struct packed {
      logic         wr_en;
      slot_idx_type wr_idx;
      logic [3:0]   replica;
      ctr_type      ctr;
      logic         clr_en;
      slot_idx_type clr_idx;
   } cct_cloud_wr_type;

   typedef struct packed {
      logic        en;
      rep_idx_type addr;
      ctr_type     data;
   } cct_vec_wr_type;

   typedef struct packed {
      logic    v_zero;
      logic    c_one;
      logic    le;
      logic    succ;
      logic    sat;
      ctr_type inc;
   } cct_cmp_type;

endpackage
`default_nettype wire

// ===== hw/rtl/cct_cmp.sv =====
// shared compare and increment unit for vector entry against counter
`default_nettype none
module cct_cmp (
   input  wire cct_pkg::ctr_type vec_value,
   input  wire cct_pkg::ctr_type dot_value,
   output cct_pkg::cct_cmp_type result
);

   logic [cct_pkg::CTR_W:0] inc_wide;

   assign inc_wide = {1'b0, vec_value} + {{cct_pkg::CTR_W{1'b0}}, 1'b1};

   always_comb begin
      result.v_zero = (vec_value == '0);
      result.c_one  = (dot_value == cct_pkg::ctr_type'(1));
      result.le     = (dot_value <= vec_value);
      result.succ   = ({1'b0, dot_value} == inc_wide);
      result.sat    = &vec_value;
      result.inc    = inc_wide[cct_pkg::CTR_W-1:0];
   end

endmodule
`default_nettype wire

// ===== hw/rtl/cct_vector.sv =====
// version vector register file, one read and one write port
`default_nettype none
module cct_vector (
   input  wire                          clock,
   input  wire                          reset,
   input  wire cct_pkg::rep_idx_type    rd_addr,
   output cct_pkg::ctr_type             rd_data,
   input  wire cct_pkg::cct_vec_wr_type wr
);

   cct_pkg::ctr_type entry_ff [cct_pkg::REPLICAS];

   assign rd_data = entry_ff[rd_addr];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cct_pkg::REPLICAS; i++) begin
            entry_ff[i] <= '0;
         end
      end else if (wr.en) begin
         entry_ff[wr.addr] <= wr.data;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/cct_cloud.sv =====
// dot cloud slots with valid bits, one read port, one fill and one clear port
`default_nettype none
module cct_cloud (
   input  wire                            clock,
   input  wire                            reset,
   input  wire cct_pkg::slot_idx_type     rd_idx,
   output cct_pkg::cct_slot_type          rd_slot,
   input  wire cct_pkg::cct_cloud_wr_type wr
);

   logic [cct_pkg::CLOUD_SLOTS-1:0] valid_ff;
   logic [3:0]                      rep_ff [cct_pkg::CLOUD_SLOTS];
   cct_pkg::ctr_type                ctr_ff [cct_pkg::CLOUD_SLOTS];

   always_comb begin
      rd_slot.valid   = valid_ff[rd_idx];
      rd_slot.replica = rep_ff[rd_idx];
      rd_slot.ctr     = ctr_ff[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (wr.clr_en) begin
            valid_ff[wr.clr_idx] <= 1'b0;
         end
         if (wr.wr_en) begin
            valid_ff[wr.wr_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr.wr_en) begin
         rep_ff[wr.wr_idx] <= wr.replica;
         ctr_ff[wr.wr_idx] <= wr.ctr;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/causal_context_tracker.sv =====
// top level: sequencer over vector, dot cloud and shared compare unit
// make, merge and unknown requests go from idle straight to the done state, which registers the result
// query scans every cloud slot before done; insert scans, then places, then compacts if asked
// compact: each pass walks all CLOUD_SLOTS slots one per cycle through the compare unit,
// repeating while a pass folds a dot, at most (CLOUD_SLOTS + 1) passes, then done
// one item at a time; busy stays high until the result; sync reset empties vector and cloud
`default_nettype none
module causal_context_tracker (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       start,
   output logic                      busy,
   input  wire cct_pkg::cct_req_type req_item,
   output logic                      rsp_valid,
   output cct_pkg::cct_rsp_type      rsp_item
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_PLACE = 3'd2;
   localparam logic [2:0] S_FOLD  = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   localparam cct_pkg::slot_idx_type LAST_SLOT =
      cct_pkg::slot_idx_type'(cct_pkg::CLOUD_SLOTS - 1);

   logic [2:0]             state_ff, state_in;
   cct_pkg::cct_req_type   req_ff, req_in;
   cct_pkg::slot_idx_type  idx_ff, idx_in;
   cct_pkg::slot_idx_type  free_idx_ff, free_idx_in;
   logic                   hit_ff, hit_in;
   logic                   free_ok_ff, free_ok_in;
   logic                   changed_ff, changed_in;
   logic [1:0]             status_ff, status_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   cct_pkg::cct_rsp_type   rsp_ff, rsp_in;

   cct_pkg::rep_idx_type     vec_rd_addr;
   cct_pkg::ctr_type         vec_rd_data;
   cct_pkg::cct_vec_wr_type  vec_wr;
   cct_pkg::cct_slot_type    slot;
   cct_pkg::cct_cloud_wr_type cloud_wr;
   cct_pkg::ctr_type         cmp_dot;
   cct_pkg::cct_cmp_type     cmp;
   logic                     fold_mode;
   logic                     req_in_range;
   logic                     new_in_range;
   logic                     slot_rep_ok;
   logic                     match;
   logic                     changed_now;
   cct_pkg::ctr_type         value;

   assign fold_mode    = (state_ff == S_FOLD);
   assign req_in_range = (32'(req_ff.replica) < 32'(cct_pkg::REPLICAS));
   assign new_in_range = (32'(req_item.replica) < 32'(cct_pkg::REPLICAS));
   assign slot_rep_ok  = (32'(slot.replica) < 32'(cct_pkg::REPLICAS));
   assign vec_rd_addr  = fold_mode ? cct_pkg::rep_idx_type'(slot.replica)
                                   : cct_pkg::rep_idx_type'(req_ff.replica);
   assign cmp_dot      = fold_mode ? slot.ctr : req_ff.dot_counter;
   assign match        = slot.valid && (slot.replica == req_ff.replica)
                         && (slot.ctr == req_ff.dot_counter);

   cct_vector u_vector (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (vec_rd_addr),
      .rd_data (vec_rd_data),
      .wr      (vec_wr)
   );

   cct_cloud u_cloud (
      .clock   (clock),
      .reset   (reset),
      .rd_idx  (idx_ff),
      .rd_slot (slot),
      .wr      (cloud_wr)
   );

   cct_cmp u_cmp (
      .vec_value (vec_rd_data),
      .dot_value (cmp_dot),
      .result    (cmp)
   );

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      idx_in       = idx_ff;
      free_idx_in  = free_idx_ff;
      hit_in       = hit_ff;
      free_ok_in   = free_ok_ff;
      changed_in   = changed_ff;
      status_in    = status_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      vec_wr       = '0;
      cloud_wr     = '0;
      changed_now  = 1'b0;
      value        = vec_rd_data;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in     = req_item;
               idx_in     = '0;
               hit_in     = 1'b0;
               free_ok_in = 1'b0;
               changed_in = 1'b0;
               status_in  = cct_pkg::ST_OK;
               if (!new_in_range) begin
                  state_in = S_DONE;
               end else if (req_item.req_type inside {cct_pkg::REQ_INSERT,
                                                      cct_pkg::REQ_QUERY}) begin
                  state_in = S_SCAN;
               end else if (req_item.req_type == cct_pkg::REQ_COMPACT) begin
                  state_in = S_FOLD;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SCAN: begin
            hit_in = hit_ff | match;
            if (!slot.valid && !free_ok_ff) begin
               free_ok_in  = 1'b1;
               free_idx_in = idx_ff;
            end
            if (idx_ff == LAST_SLOT) begin
               idx_in   = '0;
               state_in = (req_ff.req_type == cct_pkg::REQ_INSERT) ? S_PLACE : S_DONE;
            end else begin
               idx_in = idx_ff + cct_pkg::slot_idx_type'(1);
            end
         end
         S_PLACE: begin
            if (!hit_ff) begin
               if (free_ok_ff) begin
                  cloud_wr.wr_en   = 1'b1;
                  cloud_wr.wr_idx  = free_idx_ff;
                  cloud_wr.replica = req_ff.replica;
                  cloud_wr.ctr     = req_ff.dot_counter;
               end else begin
                  status_in = cct_pkg::ST_FULL;
               end
            end
            state_in = req_ff.compact_now ? S_FOLD : S_DONE;
         end
         S_FOLD: begin
            if (slot.valid && slot_rep_ok) begin
               vec_wr.addr      = vec_rd_addr;
               cloud_wr.clr_idx = idx_ff;
               if (cmp.v_zero) begin
                  if (cmp.c_one) begin
                     vec_wr.en       = 1'b1;
                     vec_wr.data     = cct_pkg::ctr_type'(1);
                     cloud_wr.clr_en = 1'b1;
                     changed_now     = 1'b1;
                  end
               end else if (cmp.succ) begin
                  vec_wr.en       = 1'b1;
                  vec_wr.data     = slot.ctr;
                  cloud_wr.clr_en = 1'b1;
                  changed_now     = 1'b1;
               end else if (cmp.le) begin
                  cloud_wr.clr_en = 1'b1;
               end
            end
            if (idx_ff == LAST_SLOT) begin
               idx_in     = '0;
               changed_in = 1'b0;
               if (!(changed_ff || changed_now)) begin
                  state_in = S_DONE;
               end
            end else begin
               idx_in     = idx_ff + cct_pkg::slot_idx_type'(1);
               changed_in = changed_ff | changed_now;
            end
         end
         S_DONE: begin
            rsp_in.known  = 1'b0;
            rsp_in.status = status_ff;
            vec_wr.addr   = vec_rd_addr;
            case (req_ff.req_type)
               cct_pkg::REQ_MAKE: begin
                  value       = cmp.sat ? vec_rd_data : cmp.inc;
                  vec_wr.en   = req_in_range;
                  vec_wr.data = value;
                  if (cmp.sat) begin
                     rsp_in.status = cct_pkg::ST_SAT;
                  end
               end
               cct_pkg::REQ_MERGE: begin
                  value       = cmp.le ? vec_rd_data : req_ff.dot_counter;
                  vec_wr.en   = req_in_range && !cmp.le;
                  vec_wr.data = value;
               end
               cct_pkg::REQ_QUERY: begin
                  rsp_in.known = (!cmp.v_zero && cmp.le) || hit_ff;
               end
               default: begin
                  value = vec_rd_data;
               end
            endcase
            rsp_in.new_counter = value;
            if (!req_in_range) begin
               rsp_in = '0;
            end
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         hit_ff       <= 1'b0;
         free_ok_ff   <= 1'b0;
         changed_ff   <= 1'b0;
         status_ff    <= cct_pkg::ST_OK;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         hit_ff       <= hit_in;
         free_ok_ff   <= free_ok_in;
         changed_ff   <= changed_in;
         status_ff    <= status_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      free_idx_ff <= free_idx_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/cct_checker.sv =====
// port level checks for the causal context tracker, bound to the top level
`default_nettype none
module cct_checker (
   input wire                       clock,
   input wire                       reset,
   input wire                       start,
   input wire                       busy,
   input wire                       rsp_valid,
   input wire cct_pkg::cct_rsp_type rsp_item
);

   // an accepted item always raises busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

   // the result strobe comes exactly as busy drops
   a_fell_rsp: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_rsp_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.status != 2'd3) && !(rsp_item.known &&
                     rsp_item.status != cct_pkg::ST_OK))
      else $error("bad result status");

endmodule

bind causal_context_tracker cct_checker u_cct_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);
`default_nettype wire

// ===== dv/tb_causal_context_tracker.sv =====
// testbench for the causal context tracker: predicts every result and checks it in order
module tb_causal_context_tracker;
   import cct_pkg::*;

   localparam logic [2:0] REQ_RESERVED_FIRST = 3'd5;
   localparam logic [2:0] REQ_RESERVED_LAST  = 3'd7;
   localparam ctr_type    CTR_MAX            = '1;
   localparam int         RUN_LIMIT          = 1000000;
   localparam int         DRAIN_CYCLES       = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   cct_req_type req_item = '0;
   logic        rsp_valid;
   cct_rsp_type rsp_item;

   ctr_type      ctx_vec[REPLICAS];
   cct_slot_type ctx_cloud[CLOUD_SLOTS];
   cct_rsp_type  pending_results[$];
   int           mismatch_count = 0;
   int           cycle_count = 0;
   logic         no_idle = 1'b0;

   causal_context_tracker uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_item(rsp_item)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
      mismatch_count++;
   endtask

   function automatic logic cloud_holds(logic [3:0] rep, ctr_type c);
      for (int i = 0; i < CLOUD_SLOTS; i++)
         if (ctx_cloud[i].valid && ctx_cloud[i].replica == rep && ctx_cloud[i].ctr == c)
            return 1'b1;
      return 1'b0;
   endfunction

   function automatic logic [1:0] cloud_add(logic [3:0] rep, ctr_type c);
      if (cloud_holds(rep, c))
         return ST_OK;
      for (int i = 0; i < CLOUD_SLOTS; i++) begin
         if (!ctx_cloud[i].valid) begin
            ctx_cloud[i].valid = 1'b1;
            ctx_cloud[i].replica = rep;
            ctx_cloud[i].ctr = c;
            return ST_OK;
         end
      end
      return ST_FULL;
   endfunction

   // fold contiguous dots into the vector and drop dominated ones until stable
   function automatic void cloud_fold();
      logic       changed;
      logic [3:0] rep;
      ctr_type    v;
      ctr_type    c;
      do begin
         changed = 1'b0;
         for (int i = 0; i < CLOUD_SLOTS; i++) begin
            if (ctx_cloud[i].valid && ctx_cloud[i].replica < REPLICAS) begin
               rep = ctx_cloud[i].replica;
               v = ctx_vec[rep];
               c = ctx_cloud[i].ctr;
               if (v == '0) begin
                  if (c == ctr_type'(1)) begin
                     ctx_vec[rep] = ctr_type'(1);
                     ctx_cloud[i].valid = 1'b0;
                     changed = 1'b1;
                  end
               end else if ({1'b0, c} == {1'b0, v} + 32'd1) begin
                  ctx_vec[rep] = c;
                  ctx_cloud[i].valid = 1'b0;
                  changed = 1'b1;
               end else if (c <= v) begin
                  ctx_cloud[i].valid = 1'b0;
               end
            end
         end
      end while (changed);
   endfunction

   function automatic cct_rsp_type predict_context(cct_req_type it);
      cct_rsp_type r;
      logic [3:0]  rep;
      ctr_type     c;
      r = '0;
      rep = it.replica;
      c = it.dot_counter;
      if (rep < REPLICAS) begin
         case (it.req_type)
            REQ_MAKE: begin
               if (ctx_vec[rep] == CTR_MAX)
                  r.status = ST_SAT;
               else
                  ctx_vec[rep] = ctx_vec[rep] + ctr_type'(1);
            end
            REQ_INSERT: begin
               r.status = cloud_add(rep, c);
               if (it.compact_now)
                  cloud_fold();
            end
            REQ_QUERY: begin
               r.known = (ctx_vec[rep] != '0 && c <= ctx_vec[rep]) || cloud_holds(rep, c);
            end
            REQ_MERGE: begin
               if (c > ctx_vec[rep])
                  ctx_vec[rep] = c;
            end
            REQ_COMPACT: begin
               cloud_fold();
            end
            default: begin
            end
         endcase
         r.new_counter = ctx_vec[rep];
      end
      return r;
   endfunction

   function automatic int idle_len();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (no_idle || sel < 50)
         return 0;
      if (sel < 90)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic cct_req_type make_req(logic [2:0] kind, logic [3:0] rep, ctr_type c,
                                            logic now);
      cct_req_type it;
      it.req_type = kind;
      it.replica = rep;
      it.dot_counter = c;
      it.compact_now = now;
      return it;
   endfunction

   function automatic ctr_type pick_counter(logic [3:0] rep);
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 40)
         return ctx_vec[rep] + ctr_type'($urandom_range(0, 3));
      if (sel < 60)
         return ctr_type'($urandom_range(0, 8));
      if (sel < 80)
         return ctr_type'($urandom());
      if (sel < 90)
         return CTR_MAX - ctr_type'($urandom_range(0, 3));
      return ctx_vec[rep] - ctr_type'($urandom_range(0, 3));
   endfunction

   function automatic logic [3:0] pick_replica();
      if ($urandom_range(0, 9) < 7)
         return 4'($urandom_range(0, 5));
      return 4'($urandom_range(0, REPLICAS - 1));
   endfunction

   task automatic issue_request(input cct_req_type it);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_results.push_back(predict_context(it));
   endtask

   always @(posedge clock) begin
      cct_rsp_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected item", rsp_item.new_counter, 0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_item.new_counter !== want.new_counter)
               report_mismatch("new_counter", rsp_item.new_counter, want.new_counter);
            if (rsp_item.known !== want.known)
               report_mismatch("known", rsp_item.known, want.known);
            if (rsp_item.status !== want.status)
               report_mismatch("status", rsp_item.status, want.status);
         end
      end
   end

   task automatic test_basic_ops();
      issue_request(make_req(REQ_MAKE, 4'd0, 31'd0, 1'b0));
      issue_request(make_req(REQ_QUERY, 4'd0, 31'd1, 1'b0));
      issue_request(make_req(REQ_QUERY, 4'd0, 31'd0, 1'b1));
      issue_request(make_req(REQ_QUERY, 4'd1, 31'd0, 1'b0));
      // empty entry: only a counter of one folds in
      issue_request(make_req(REQ_INSERT, 4'd1, 31'd3, 1'b1));
      issue_request(make_req(REQ_QUERY, 4'd1, 31'd3, 1'b0));
      issue_request(make_req(REQ_INSERT, 4'd1, 31'd3, 1'b0));
      issue_request(make_req(REQ_INSERT, 4'd1, 31'd1, 1'b0));
      issue_request(make_req(REQ_COMPACT, 4'd1, 31'd0, 1'b0));
      issue_request(make_req(REQ_INSERT, 4'd1, 31'd2, 1'b1));
      issue_request(make_req(REQ_MERGE, 4'd2, 31'd0, 1'b0));
      issue_request(make_req(REQ_MERGE, 4'd2, CTR_MAX - 31'd1, 1'b1));
      issue_request(make_req(REQ_MAKE, 4'd2, 31'd0, 1'b0));
      // counter saturation
      issue_request(make_req(REQ_MAKE, 4'd2, CTR_MAX, 1'b1));
      issue_request(make_req(REQ_INSERT, 4'd2, CTR_MAX, 1'b1));
      issue_request(make_req(REQ_MERGE, 4'd3, 31'd5, 1'b0));
      issue_request(make_req(REQ_INSERT, 4'd3, 31'd2, 1'b1));
      issue_request(make_req(REQ_QUERY, 4'd15, CTR_MAX, 1'b0));
      issue_request(make_req(REQ_INSERT, 4'd15, 31'd0, 1'b1));
      issue_request(make_req(REQ_QUERY, 4'd15, 31'd0, 1'b1));
      for (int k = REQ_RESERVED_FIRST; k <= REQ_RESERVED_LAST; k++)
         issue_request(make_req(3'(k), 4'd2, ctr_type'($urandom()), 1'b1));
   endtask

   task automatic test_cloud_full();
      for (int i = 0; i < CLOUD_SLOTS + 2; i++)
         issue_request(make_req(REQ_INSERT, 4'd4, ctr_type'(10 + i), 1'b0));
      // duplicate while full is not a drop
      issue_request(make_req(REQ_INSERT, 4'd4, 31'd12, 1'b0));
      issue_request(make_req(REQ_INSERT, 4'd5, 31'd1, 1'b1));
      issue_request(make_req(REQ_MERGE, 4'd4, 31'd20, 1'b0));
      issue_request(make_req(REQ_COMPACT, 4'd4, 31'd0, 1'b1));
      issue_request(make_req(REQ_QUERY, 4'd4, 31'd25, 1'b0));
   endtask

   task automatic test_context_join(input int n_items);
      int         sent;
      int         n_merge;
      int         n_ins;
      logic [3:0] rep;
      sent = 0;
      while (sent < n_items) begin
         no_idle = ($urandom_range(0, 3) == 0);
         n_merge = $urandom_range(0, 4);
         n_ins = $urandom_range(1, 8);
         for (int i = 0; i < n_merge; i++) begin
            rep = pick_replica();
            issue_request(make_req(REQ_MERGE, rep, pick_counter(rep), 1'($urandom())));
         end
         for (int i = 0; i < n_ins; i++) begin
            rep = pick_replica();
            issue_request(make_req(REQ_INSERT, rep,
                                   ctx_vec[rep] + ctr_type'($urandom_range(0, 6)),
                                   $urandom_range(0, 9) == 0));
         end
         // occasionally a broken join with no closing compact
         if ($urandom_range(0, 9) != 0)
            issue_request(make_req(REQ_COMPACT, pick_replica(), ctr_type'($urandom()),
                                   1'($urandom())));
         if ($urandom_range(0, 1) == 0)
            issue_request(make_req(REQ_QUERY, rep, pick_counter(rep), 1'($urandom())));
         sent += n_merge + n_ins + 2;
      end
   endtask

   task automatic test_random_mix(input int n_items);
      int unsigned sel;
      logic [2:0]  kind;
      logic [3:0]  rep;
      for (int n = 0; n < n_items; n++) begin
         if (n % 50 == 0)
            no_idle = ($urandom_range(0, 3) == 0);
         sel = $urandom_range(0, 99);
         if (sel < 20)
            kind = REQ_MAKE;
         else if (sel < 50)
            kind = REQ_INSERT;
         else if (sel < 75)
            kind = REQ_QUERY;
         else if (sel < 85)
            kind = REQ_MERGE;
         else if (sel < 95)
            kind = REQ_COMPACT;
         else
            kind = 3'($urandom_range(REQ_RESERVED_FIRST, REQ_RESERVED_LAST));
         rep = pick_replica();
         issue_request(make_req(kind, rep, pick_counter(rep), 1'($urandom())));
      end
   endtask

   initial begin
      for (int i = 0; i < REPLICAS; i++)
         ctx_vec[i] = '0;
      for (int i = 0; i < CLOUD_SLOTS; i++)
         ctx_cloud[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_basic_ops();
      test_cloud_full();
      test_context_join(300);
      test_random_mix(500);
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
